/* hw/rtl/lcdsf_pkg.sv */
// Shared constants, types and helper functions of the LCD subpixel FIR decimator.
package lcdsf_pkg;

   localparam int unsigned NUM_CHAN    = 3;
   localparam int unsigned NUM_TAPS    = 12;
   localparam int unsigned WIN_DEPTH   = NUM_TAPS - 1;
   localparam int unsigned GROUP_TAPS  = 4;
   localparam int unsigned NUM_GROUPS  = NUM_TAPS / GROUP_TAPS;
   localparam int unsigned SAMPLE_W    = 8;
   localparam int unsigned COEF_W      = 7;
   localparam int unsigned PROD_W      = 14;   // 0x40 * 255 fits
   localparam int unsigned QUAD_W      = 16;   // four taps summed
   localparam int unsigned ACC_W       = 17;   // twelve taps summed
   localparam int unsigned SUM_SHIFT   = 8;    // divide by 0x100
   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned CHAN_SEL_W  = 2;
   localparam int unsigned LUT_DEPTH   = 256;
   localparam int unsigned PIXEL_W     = 16;
   localparam int unsigned OUT_DEPTH   = 4;    // result queue, power of two

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // operation codes of an input beat
   localparam logic OP_SAMPLE   = 1'b0;
   localparam logic OP_TABLE_WR = 1'b1;

   // pixel phase within a group of four samples
   localparam logic [1:0] PIX_PHASE       = 2'd3;
   localparam logic [1:0] TAILS_ALIGNED   = 2'd2;
   localparam logic [1:0] TAILS_UNALIGNED = 2'd3;
   localparam logic [1:0] TAILS_LAST      = 2'd1;

   localparam logic [COEF_W-1:0] FIR_COEF [NUM_CHAN][NUM_TAPS] = '{
      '{7'h03, 7'h0b, 7'h1c, 7'h33, 7'h40, 7'h39, 7'h24, 7'h10, 7'h05, 7'h01, 7'h00, 7'h00},
      '{7'h00, 7'h02, 7'h08, 7'h16, 7'h2b, 7'h3d, 7'h3d, 7'h2b, 7'h16, 7'h08, 7'h02, 7'h00},
      '{7'h00, 7'h00, 7'h01, 7'h05, 7'h10, 7'h24, 7'h39, 7'h40, 7'h33, 7'h1c, 7'h0b, 7'h03}
   };

   typedef logic [NUM_CHAN-1:0][COEF_W-1:0] coef_col_type;
   typedef logic [NUM_CHAN-1:0][PROD_W-1:0] prod_col_type;
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_col_type;

   // token control travelling down the back end
   typedef struct packed {
      logic pix;
      logic wr;
      logic last;
   } tok_ctl_type;

   typedef struct packed {
      logic [CHAN_SEL_W-1:0] chan;
      logic [CHAN_W-1:0]     index;
      logic [CHAN_W-1:0]     value;
   } lut_wr_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } res_type;

   function automatic coef_col_type tap_coefs(input int unsigned tap);
      coef_col_type r;
      for (int c = 0; c < NUM_CHAN; c++) begin
         r[c] = FIR_COEF[c][tap];
      end
      return r;
   endfunction

   function automatic prod_col_type tap_products(input coef_col_type coefs,
                                                 input logic [SAMPLE_W-1:0] s);
      prod_col_type p;
      for (int c = 0; c < NUM_CHAN; c++) begin
         p[c] = PROD_W'(coefs[c]) * PROD_W'(s);
      end
      return p;
   endfunction

endpackage

/* hw/rtl/lcd_subpixel_fir_decimator.sv */
// Top level of the LCD subpixel FIR decimator: window cells, filter sums, gamma and result queue.
//
// Takes one row of 8-bit coverage samples at 4x horizontal resolution and
// emits RGB565 pixels, one per four samples. Pixel p is filtered from
// samples 4p-8 .. 4p+3 by fixed 12-tap red, green and blue filters; each sum
// is divided by 256, clamped to 255, optionally mapped through its channel's
// gamma table (csr_wr_data = 1 enables) and packed. A beat with row_end set
// ends the row: the window is flushed with zeros to give the two or three
// remaining pixels, the last one flagged last_of_row, then cleared. Table
// writes (operation 1) go down the same pipeline as pixels, so they land in
// order with the pixels around them; channel 3 is ignored. Reading an entry
// never written while gamma is on gives an undefined channel value.
// Rate: one beat (sample or table write) per cycle. After a row_end sample
// req_ready stays low while the eleven window cells shift zeros in, one per
// cycle while there is room for a result. req_ready also drops while
// OUT_DEPTH results are in flight or queued. A pixel passes the stage A, B
// and C registers and the result queue. OUT_DEPTH is a power of two, 2 or more.
module lcd_subpixel_fir_decimator #(
   parameter int unsigned OUT_DEPTH = lcdsf_pkg::OUT_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input beats
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic [lcdsf_pkg::SAMPLE_W-1:0]        req_coverage,
   input  logic                                  req_row_end,
   input  logic [lcdsf_pkg::CHAN_SEL_W-1:0]      req_table_channel,
   input  logic [lcdsf_pkg::CHAN_W-1:0]          req_table_index,
   input  logic [lcdsf_pkg::CHAN_W-1:0]          req_table_value,
   // result beats
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [lcdsf_pkg::PIXEL_W-1:0]         rsp_pixel_rgb565,
   output logic                                  rsp_last_of_row,
   // apply_gamma register
   input  logic                                  csr_wr_en,
   input  logic                                  csr_wr_data
);

   localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_STREAM = 2'b01,
      ST_FLUSH  = 2'b10
   } seq_state_type;

   // ---------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------
   seq_state_type state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;    // row position mod 4
   logic [1:0]    tails_ff, tails_in;    // flush pixels still owed
   logic [CW-1:0] credit_ff, credit_in;  // pixels in flight plus queued
   logic          apply_gamma_ff;

   logic room;
   logic accept;
   logic smp_acc;
   logic wr_acc;
   logic flush_step;
   logic shift_en;
   logic fire;
   logic row_done;
   logic pop;
   logic [lcdsf_pkg::SAMPLE_W-1:0] shift_val;

   assign room       = (credit_ff != CW'(OUT_DEPTH));
   assign req_ready  = (state_ff == ST_STREAM) && room;
   assign accept     = req_valid && req_ready;
   assign smp_acc    = accept && (req_operation == lcdsf_pkg::OP_SAMPLE);
   assign wr_acc     = accept && (req_operation == lcdsf_pkg::OP_TABLE_WR);
   assign flush_step = (state_ff == ST_FLUSH) && room;
   assign shift_en   = smp_acc || flush_step;
   assign fire       = shift_en && (phase_ff == lcdsf_pkg::PIX_PHASE);
   assign row_done   = flush_step && fire && (tails_ff == lcdsf_pkg::TAILS_LAST);
   assign shift_val  = flush_step ? '0 : req_coverage;
   assign pop        = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      tails_in = tails_ff;
      unique case (state_ff)
         ST_STREAM: begin
            if (smp_acc) begin
               phase_in = phase_ff + 2'd1;
               if (req_row_end) begin
                  state_in = ST_FLUSH;
                  // row length a multiple of four once this sample is in
                  tails_in = (phase_ff == lcdsf_pkg::PIX_PHASE) ?
                             lcdsf_pkg::TAILS_ALIGNED : lcdsf_pkg::TAILS_UNALIGNED;
               end
            end
         end
         ST_FLUSH: begin
            if (row_done) begin
               state_in = ST_STREAM;
               phase_in = '0;
            end else if (flush_step) begin
               phase_in = phase_ff + 2'd1;
               if (fire) begin
                  tails_in = tails_ff - 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_STREAM;
         end
      endcase
   end

   assign credit_in = credit_ff + CW'(fire) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_STREAM;
         phase_ff       <= '0;
         tails_ff       <= '0;
         credit_ff      <= '0;
         apply_gamma_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         tails_ff  <= tails_in;
         credit_ff <= credit_in;
         if (csr_wr_en) begin
            apply_gamma_ff <= csr_wr_data;
         end
      end
   end

   // ---------------------------------------------------------------
   // Window: eleven cells, oldest at 0; the incoming sample is tap 11
   // ---------------------------------------------------------------
   logic [lcdsf_pkg::SAMPLE_W-1:0] win_q [lcdsf_pkg::WIN_DEPTH];
   lcdsf_pkg::prod_col_type        tap_prod [lcdsf_pkg::NUM_TAPS];

   for (genvar k = 0; k < lcdsf_pkg::WIN_DEPTH; k++) begin : g_cell
      logic [lcdsf_pkg::SAMPLE_W-1:0] from_right;

      if (k == lcdsf_pkg::WIN_DEPTH - 1) begin : g_head
         assign from_right = shift_val;
      end else begin : g_body
         assign from_right = win_q[k+1];
      end

      lcdsf_tap_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .clear      (row_done),
         .coef_in    (lcdsf_pkg::tap_coefs(k)),
         .shift_data (from_right),
         .sample_out (win_q[k]),
         .prod_out   (tap_prod[k])
      );
   end

   assign tap_prod[lcdsf_pkg::NUM_TAPS-1] =
      lcdsf_pkg::tap_products(lcdsf_pkg::tap_coefs(lcdsf_pkg::NUM_TAPS - 1), shift_val);

   // ---------------------------------------------------------------
   // Stage A: partial sums over groups of four taps
   // ---------------------------------------------------------------
   logic [lcdsf_pkg::QUAD_W-1:0] quad_in [lcdsf_pkg::NUM_CHAN][lcdsf_pkg::NUM_GROUPS];
   logic [lcdsf_pkg::QUAD_W-1:0] quad_a_ff [lcdsf_pkg::NUM_CHAN][lcdsf_pkg::NUM_GROUPS];
   lcdsf_pkg::tok_ctl_type       ctl_a_ff;
   lcdsf_pkg::lut_wr_type        wrd_a_ff;

   always_comb begin
      for (int c = 0; c < lcdsf_pkg::NUM_CHAN; c++) begin
         for (int g = 0; g < lcdsf_pkg::NUM_GROUPS; g++) begin
            quad_in[c][g] = '0;
            for (int j = 0; j < lcdsf_pkg::GROUP_TAPS; j++) begin
               quad_in[c][g] = quad_in[c][g] +
                  lcdsf_pkg::QUAD_W'(tap_prod[g*lcdsf_pkg::GROUP_TAPS + j][c]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
      end else begin
         ctl_a_ff.pix  <= fire;
         ctl_a_ff.wr   <= wr_acc;
         ctl_a_ff.last <= row_done;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         quad_a_ff <= quad_in;
      end
      if (wr_acc) begin
         wrd_a_ff.chan  <= req_table_channel;
         wrd_a_ff.index <= req_table_index;
         wrd_a_ff.value <= req_table_value;
      end
   end

   // ---------------------------------------------------------------
   // Stage B: full sum, divide by 256, clamp to 255
   // ---------------------------------------------------------------
   logic [lcdsf_pkg::ACC_W-1:0]           sum_b [lcdsf_pkg::NUM_CHAN];
   logic [lcdsf_pkg::ACC_W-lcdsf_pkg::SUM_SHIFT-1:0] scaled_b [lcdsf_pkg::NUM_CHAN];
   lcdsf_pkg::chan_col_type               chan_in;
   lcdsf_pkg::chan_col_type               chan_b_ff;
   lcdsf_pkg::tok_ctl_type                ctl_b_ff;
   lcdsf_pkg::lut_wr_type                 wrd_b_ff;

   always_comb begin
      for (int c = 0; c < lcdsf_pkg::NUM_CHAN; c++) begin
         sum_b[c] = lcdsf_pkg::ACC_W'(quad_a_ff[c][0]) +
                    lcdsf_pkg::ACC_W'(quad_a_ff[c][1]) +
                    lcdsf_pkg::ACC_W'(quad_a_ff[c][2]);
         scaled_b[c] = sum_b[c][lcdsf_pkg::ACC_W-1:lcdsf_pkg::SUM_SHIFT];
         chan_in[c]  = (scaled_b[c] > (lcdsf_pkg::ACC_W - lcdsf_pkg::SUM_SHIFT)'(lcdsf_pkg::CHAN_MAX))
                       ? lcdsf_pkg::CHAN_MAX : scaled_b[c][lcdsf_pkg::CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else begin
         ctl_b_ff <= ctl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_a_ff.pix) begin
         chan_b_ff <= chan_in;
      end
      if (ctl_a_ff.wr) begin
         wrd_b_ff <= wrd_a_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage C: gamma tables and packing, then the result queue
   // ---------------------------------------------------------------
   logic               push_valid;
   lcdsf_pkg::res_type push_data;
   lcdsf_pkg::res_type pop_data;

   lcdsf_gamma_lut u_gamma (
      .clock       (clock),
      .reset       (reset),
      .apply_gamma (apply_gamma_ff),
      .ctl_in      (ctl_b_ff),
      .chan_in     (chan_b_ff),
      .wr_in       (wrd_b_ff),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   lcdsf_out_fifo #(
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_ready  (rsp_ready),
      .pop_valid  (rsp_valid),
      .pop_data   (pop_data)
   );

   assign rsp_pixel_rgb565 = pop_data.pixel;
   assign rsp_last_of_row  = pop_data.last;

endmodule

/* hw/rtl/lcdsf_tap_cell.sv */
// One cell of the sample window: holds a sample, shifts it on, forms its three tap products.
module lcdsf_tap_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift_en,
   input  logic                                clear,
   input  lcdsf_pkg::coef_col_type             coef_in,
   input  logic [lcdsf_pkg::SAMPLE_W-1:0]      shift_data,
   output logic [lcdsf_pkg::SAMPLE_W-1:0]      sample_out,
   output lcdsf_pkg::prod_col_type             prod_out
);

   logic [lcdsf_pkg::SAMPLE_W-1:0] sample_ff;
   logic [lcdsf_pkg::SAMPLE_W-1:0] sample_in;

   // clear wins over shift: row end empties the window
   always_comb begin
      if (clear) begin
         sample_in = '0;
      end else if (shift_en) begin
         sample_in = shift_data;
      end else begin
         sample_in = sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;
   assign prod_out   = lcdsf_pkg::tap_products(coef_in, sample_ff);

endmodule

/* hw/rtl/lcdsf_gamma_lut.sv */
// Gamma tables per channel, optional mapping and RGB565 packing.
module lcdsf_gamma_lut (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     apply_gamma,
   input  lcdsf_pkg::tok_ctl_type   ctl_in,
   input  lcdsf_pkg::chan_col_type  chan_in,
   input  lcdsf_pkg::lut_wr_type    wr_in,
   output logic                     push_valid,
   output lcdsf_pkg::res_type       push_data
);

   logic [lcdsf_pkg::CHAN_W-1:0] lut_rd_ff [lcdsf_pkg::NUM_CHAN];
   lcdsf_pkg::chan_col_type      raw_ff;
   lcdsf_pkg::chan_col_type      mapped;
   logic                         pix_ff;
   logic                         last_ff;

   // one table per channel; writes and reads come in token order, never both at once
   for (genvar c = 0; c < lcdsf_pkg::NUM_CHAN; c++) begin : g_lut
      logic [lcdsf_pkg::CHAN_W-1:0] lut_mem_ff [lcdsf_pkg::LUT_DEPTH];

      always_ff @(posedge clock) begin
         if (ctl_in.wr && (wr_in.chan == lcdsf_pkg::CHAN_SEL_W'(c))) begin
            lut_mem_ff[wr_in.index] <= wr_in.value;
         end
         if (ctl_in.pix) begin
            lut_rd_ff[c] <= lut_mem_ff[chan_in[c]];
         end
      end

      assign mapped[c] = apply_gamma ? lut_rd_ff[c] : raw_ff[c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff  <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         pix_ff  <= ctl_in.pix;
         last_ff <= ctl_in.last;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.pix) begin
         raw_ff <= chan_in;
      end
   end

   // top 5/6/5 bits of red, green, blue
   assign push_valid      = pix_ff;
   assign push_data.pixel = {mapped[0][7:3], mapped[1][7:2], mapped[2][7:3]};
   assign push_data.last  = last_ff;

endmodule

/* hw/rtl/lcdsf_out_fifo.sv */
// Result queue between the filter pipeline and the response channel.
module lcdsf_out_fifo #(
   parameter int unsigned DEPTH = lcdsf_pkg::OUT_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  lcdsf_pkg::res_type  push_data,
   input  logic                pop_ready,
   output logic                pop_valid,
   output lcdsf_pkg::res_type  pop_data
);

   localparam int unsigned PW = $clog2(DEPTH);

   lcdsf_pkg::res_type entry_ff [DEPTH];
   logic [PW-1:0]      head_ff;
   logic [PW-1:0]      head_in;
   logic [PW-1:0]      tail_ff;
   logic [PW-1:0]      tail_in;
   logic [PW:0]        fill_ff;
   logic [PW:0]        fill_in;
   logic               pop;

   // the credit count upstream keeps pushes within DEPTH
   assign pop_valid = (fill_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = entry_ff[head_ff];

   always_comb begin
      head_in = pop        ? head_ff + 1'b1 : head_ff;
      tail_in = push_valid ? tail_ff + 1'b1 : tail_ff;
      fill_in = fill_ff + (PW+1)'(push_valid) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/lcdsf_checker.sv */
// Port-level checks for the LCD subpixel FIR decimator, bound to the top level.
module lcdsf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_operation,
   input logic req_row_end,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a result beat waiting on the sink is not withdrawn
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the beat was taken");

   // nothing queued straight after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // row end: input held off while the window is flushed with zeros
   a_flush_stall : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == lcdsf_pkg::OP_SAMPLE) && req_row_end
      |=> !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready
          ##1 !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("input taken during row-end flush");

endmodule

bind lcd_subpixel_fir_decimator lcdsf_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_operation (req_operation),
   .req_row_end   (req_row_end),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready)
);

/* verif/lcd_subpixel_fir_decimator_test.sv */
// Self-checking testbench of the LCD subpixel FIR decimator: directed rows, gamma tables, random rows.
`timescale 1ns / 100ps

module lcd_subpixel_fir_decimator_test;

   // Gamma table select codes carried by a table write beat
   localparam logic [1:0] CH_RED    = 2'd0;
   localparam logic [1:0] CH_GREEN  = 2'd1;
   localparam logic [1:0] CH_BLUE   = 2'd2;
   localparam logic [1:0] CH_UNUSED = 2'd3;

   // Filter taps, oldest sample first
   localparam int unsigned FILTER_COEF [3][12] = '{
      '{3, 11, 28, 51, 64, 57, 36, 16, 5, 1, 0, 0},
      '{0, 2, 8, 22, 43, 61, 61, 43, 22, 8, 2, 0},
      '{0, 0, 1, 5, 16, 36, 57, 64, 51, 28, 11, 3}
   };

   // Cycles to let pass once nothing is expected: enough for the pipeline
   // and the zero flush after a row end, with margin.
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   // With gamma on, coverage stays below this, so every filtered channel
   // (coefficient sum 272) stays below it too and only these entries are read.
   localparam int unsigned GAMMA_SPAN    = 16;

   typedef struct packed {
      logic       op;
      logic [7:0] coverage;
      logic       row_end;
      logic [1:0] chan;
      logic [7:0] index;
      logic [7:0] value;
   } req_beat_type;

   typedef struct packed {
      logic [15:0] rgb565;
      logic        last;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = lcdsf_pkg::OP_SAMPLE;
   logic [7:0]  req_coverage = '0;
   logic        req_row_end = 1'b0;
   logic [1:0]  req_table_channel = CH_RED;
   logic [7:0]  req_table_index = '0;
   logic [7:0]  req_table_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_pixel_rgb565;
   logic        rsp_last_of_row;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   // Predictor state: the eleven previous samples of the row, the position in
   // the row, the three gamma tables and the gamma enable as last written.
   logic [7:0]  window_hist [11];
   logic [7:0]  taps [12];
   logic [15:0] row_pos;
   logic [7:0]  gamma_lut [3][256];
   logic        gamma_on;

   pixel_type   pending_pixels [$];
   int unsigned err_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   logic [7:0]  stall_pattern = 8'hff;

   lcd_subpixel_fir_decimator uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_coverage      (req_coverage),
      .req_row_end       (req_row_end),
      .req_table_channel (req_table_channel),
      .req_table_index   (req_table_index),
      .req_table_value   (req_table_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_rgb565  (rsp_pixel_rgb565),
      .rsp_last_of_row   (rsp_last_of_row),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver back-pressure: an 8-bit ready pattern, re-chosen when the low six bits of the cycle count are zero.
   // Roughly a third of the time it is all ones, so there are stall-free runs.
   always @(posedge clock) begin
      if (cycle_count[5:0] == 6'd0) begin
         case ($urandom_range(0, 2))
            0: stall_pattern = 8'hff;
            1: stall_pattern = 8'($urandom) | 8'h01;
            default: stall_pattern = 8'h01 << $urandom_range(0, 7);
         endcase
      end
      rsp_ready <= stall_pattern[cycle_count[2:0]];
   end

   task automatic report_mismatch(input string what);
      err_count++;
      if (err_count <= 40)
         $display("[cycle %0d] mismatch: %s", cycle_count, what);
   endtask

   // Result checker. Sampled at the falling edge, where valid and ready are
   // settled: a beat seen here is taken at the next rising edge.
   always @(negedge clock) begin
      pixel_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel %h last %b",
                                      rsp_pixel_rgb565, rsp_last_of_row));
         end else begin
            due = pending_pixels.pop_front();
            if (rsp_pixel_rgb565 !== due.rgb565)
               report_mismatch($sformatf("pixel %h, due %h", rsp_pixel_rgb565, due.rgb565));
            if (rsp_last_of_row !== due.last)
               report_mismatch($sformatf("last_of_row %b, due %b (pixel %h)",
                                         rsp_last_of_row, due.last, due.rgb565));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Three FIRs over the current taps, /256, clamp, optional gamma, RGB565.
   function automatic logic [15:0] filtered_pixel();
      int unsigned acc;
      logic [7:0]  chan_val [3];
      for (int c = 0; c < 3; c++) begin
         acc = 0;
         for (int k = 0; k < 12; k++)
            acc += FILTER_COEF[c][k] * taps[k];
         acc = acc >> 8;
         if (acc > 255)
            acc = 255;
         chan_val[c] = gamma_on ? gamma_lut[c][acc[7:0]] : acc[7:0];
      end
      return {chan_val[0][7:3], chan_val[1][7:2], chan_val[2][7:3]};
   endfunction

   // Shift one sample into the window; phase 3 of a group completes a pixel.
   task automatic advance_window(input logic [7:0] sample, input logic last,
                                 output bit made);
      for (int k = 0; k < 11; k++)
         taps[k] = window_hist[k];
      taps[11] = sample;
      for (int k = 0; k < 11; k++)
         window_hist[k] = taps[k + 1];
      made = (row_pos[1:0] == 2'd3);
      if (made)
         pending_pixels.push_back('{rgb565: filtered_pixel(), last: last});
      row_pos = row_pos + 16'd1;
   endtask

   task automatic clear_row();
      for (int k = 0; k < 11; k++)
         window_hist[k] = '0;
      row_pos = '0;
   endtask

   task automatic predict_beat(input req_beat_type b);
      bit made;
      int unsigned tails;
      int unsigned n;
      if (b.op == lcdsf_pkg::OP_TABLE_WR) begin
         // no pixel; the unused select drops the write
         if (b.chan != CH_UNUSED)
            gamma_lut[b.chan][b.index] = b.value;
      end else begin
         advance_window(b.coverage, 1'b0, made);
         if (b.row_end) begin
            // flush with zeros: two pixels if the row fills its last group, else three
            tails = (row_pos[1:0] == 2'd0) ? 2 : 3;
            n = 0;
            while (n < tails) begin
               advance_window(8'd0, n == tails - 1, made);
               if (made)
                  n++;
            end
            clear_row();
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_beat_type sample_beat(input logic [7:0] cov, input logic row_end);
      req_beat_type b;
      b = req_beat_type'($bits(req_beat_type)'($urandom));   // unused fields carry noise
      b.op       = lcdsf_pkg::OP_SAMPLE;
      b.coverage = cov;
      b.row_end  = row_end;
      return b;
   endfunction

   function automatic req_beat_type table_beat(input logic [1:0] chan, input logic [7:0] index,
                                               input logic [7:0] value);
      req_beat_type b;
      b = req_beat_type'($bits(req_beat_type)'($urandom));
      b.op    = lcdsf_pkg::OP_TABLE_WR;
      b.chan  = chan;
      b.index = index;
      b.value = value;
      return b;
   endfunction

   // Full range with gamma off; small values with gamma on so that only
   // the loaded gamma entries are ever read.
   function automatic logic [7:0] random_coverage();
      if (gamma_on)
         return 8'($urandom_range(0, GAMMA_SPAN - 1));
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // Sender works in bursts; between bursts valid may drop for a random gap.
   // Called at a rising edge, returns at the edge that took the beat.
   task automatic send_beat(input req_beat_type b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_operation     <= b.op;
      req_coverage      <= b.coverage;
      req_row_end       <= b.row_end;
      req_table_channel <= b.chan;
      req_table_index   <= b.index;
      req_table_value   <= b.value;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      predict_beat(b);
   endtask

   // Hold the sender until every due pixel is out and the pipe has settled.
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_gamma(input logic enable);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= enable;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      gamma_on = enable;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Gamma off: one-sample row, full-scale row (clamps), short rows of each
   // length class, table writes in mid-row (row state must survive them).
   task automatic test_plain_rows();
      set_gamma(1'b0);
      send_beat(sample_beat(8'hff, 1'b1));
      repeat (15) send_beat(sample_beat(8'hff, 1'b0));
      send_beat(sample_beat(8'hff, 1'b1));
      send_beat(sample_beat(8'h00, 1'b0));
      send_beat(table_beat(CH_RED, 8'h00, 8'hff));
      send_beat(sample_beat(8'hff, 1'b0));
      send_beat(table_beat(CH_UNUSED, 8'hff, 8'h00));
      send_beat(sample_beat(8'h00, 1'b1));
      for (int i = 0; i < 6; i++)
         send_beat(sample_beat(i[0] ? 8'h55 : 8'haa, i == 5));
      repeat (2) send_beat(sample_beat(8'h00, 1'b0));
      send_beat(sample_beat(8'h80, 1'b1));
   endtask

   // Load the low entries of every gamma table, then gamma on. A write lands
   // between the pixels around it, so a mid-row write to the red entry that
   // the next pixel reads (entry 0 for this row start) must show at once.
   task automatic test_gamma_tables();
      for (int c = 0; c < 3; c++)
         for (int i = 0; i < GAMMA_SPAN; i++)
            send_beat(table_beat(2'(c), 8'(i), 8'($urandom)));
      set_gamma(1'b1);
      repeat (3) send_beat(sample_beat(8'h0f, 1'b0));
      send_beat(table_beat(CH_RED, 8'h00, 8'hff));
      send_beat(table_beat(CH_UNUSED, 8'h00, 8'h00));
      send_beat(sample_beat(8'h0f, 1'b0));
      send_beat(table_beat(CH_BLUE, 8'h00, 8'hff));
      send_beat(table_beat(CH_GREEN, 8'h01, 8'h00));
      send_beat(sample_beat(8'h00, 1'b1));
      send_beat(sample_beat(8'h00, 1'b1));
   endtask

   // Random rows, mostly short, with table writes (some to the unused
   // select) scattered between samples.
   task automatic test_random_rows(input int unsigned n_items);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
         for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               send_beat(table_beat(2'($urandom), 8'($urandom), 8'($urandom)));
               if (req_table_channel != CH_UNUSED)
                  sent++;
            end
            send_beat(sample_beat(random_coverage(), i == len - 1));
            sent++;
         end
      end
   endtask

   initial begin
      for (int k = 0; k < 11; k++)
         window_hist[k] = '0;
      row_pos  = '0;
      gamma_on = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_rows();
      test_gamma_tables();
      test_random_rows(80);
      wait_drained();   // sender held until every pixel is out
      test_random_rows(40);
      set_gamma(1'b0);
      test_random_rows(80);
      set_gamma(1'b1);
      test_random_rows(40);

      wait_drained();
      if (err_count == 0 && pending_pixels.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
